[rtl/core/fenwick_point_set_range_sum_assert.svh]
// Assertion macros for the Fenwick range-sum block.
// Expects clk and rst to be visible where the macros are used.
`ifndef FENWICK_POINT_SET_RANGE_SUM_ASSERT_SVH
`define FENWICK_POINT_SET_RANGE_SUM_ASSERT_SVH

// cond must hold at every clock edge out of reset
`define FWK_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// trig at one edge implies cons at the next edge
`define FWK_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

[rtl/core/fwk_pkg.sv]
// Shared constants and control/status types for the Fenwick range-sum block.
// No dependencies.
package fwk_pkg;

  localparam int NUM_ELEMENTS = 1024;
  localparam int IDX_W        = $clog2(NUM_ELEMENTS);
  localparam int NODE_W       = IDX_W + 1;   // tree nodes run 1..NUM_ELEMENTS
  localparam int DATA_W       = 32;

  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;    // write zero at the clear counter, advance it
    logic capture;       // latch command fields, seed node for a query
    logic elem_write;    // store new element, latch delta
    logic load_up_node;  // node = index + 1
    logic tree_write;    // tree[node] += delta
    logic step_up;       // node += lowbit(node)
    logic q_accum;       // acc +/- tree[node], clear lowest set bit
    logic q_sub;         // subtract on the second chain
    logic load_left;     // node = left
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic node_zero;
    logic up_last;
  } sts_t;

endpackage

[rtl/core/fwk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fwk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/fwk_dp.sv]
// Datapath: element and tree memories, node walker, delta and accumulator.
// Depends on fwk_pkg and fwk_ram.
module fwk_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  fwk_pkg::ctl_t                      ctl,
  output fwk_pkg::sts_t                      sts,
  input  logic                               command,
  input  logic [fwk_pkg::IDX_W-1:0]          index,
  input  logic signed [fwk_pkg::DATA_W-1:0]  value,
  input  logic [fwk_pkg::IDX_W-1:0]          left,
  input  logic [fwk_pkg::IDX_W-1:0]          right,
  output logic signed [fwk_pkg::DATA_W-1:0]  range_sum
);

  logic [fwk_pkg::IDX_W-1:0]  clear_cnt;
  logic [fwk_pkg::IDX_W-1:0]  index_r;
  logic [fwk_pkg::IDX_W-1:0]  left_r;
  logic [fwk_pkg::DATA_W-1:0] value_r;
  logic [fwk_pkg::DATA_W-1:0] delta;
  logic [fwk_pkg::DATA_W-1:0] acc;
  logic [fwk_pkg::NODE_W-1:0] node;
  logic [fwk_pkg::NODE_W-1:0] node_dec;
  logic [fwk_pkg::NODE_W-1:0] lowbit;
  logic [fwk_pkg::NODE_W:0]   up_sum;

  logic                       elem_we;
  logic [fwk_pkg::IDX_W-1:0]  elem_waddr;
  logic [fwk_pkg::DATA_W-1:0] elem_wdata;
  logic [fwk_pkg::DATA_W-1:0] elem_rdata;
  logic                       tree_we;
  logic [fwk_pkg::IDX_W-1:0]  tree_waddr;
  logic [fwk_pkg::DATA_W-1:0] tree_wdata;
  logic [fwk_pkg::IDX_W-1:0]  tree_addr;
  logic [fwk_pkg::DATA_W-1:0] tree_rdata;

  // node n lives at address n-1
  assign node_dec  = node - fwk_pkg::NODE_W'(1);
  assign tree_addr = node_dec[fwk_pkg::IDX_W-1:0];
  assign lowbit    = node & (~node + fwk_pkg::NODE_W'(1));
  assign up_sum    = {1'b0, node} + {1'b0, lowbit};

  assign sts.clear_last = (clear_cnt == {fwk_pkg::IDX_W{1'b1}});
  assign sts.node_zero  = (node == '0);
  assign sts.up_last    = (up_sum > (fwk_pkg::NODE_W+1)'(fwk_pkg::NUM_ELEMENTS));

  assign elem_we    = ctl.clear_step | ctl.elem_write;
  assign elem_waddr = ctl.clear_step ? clear_cnt : index_r;
  assign elem_wdata = ctl.clear_step ? '0 : value_r;

  assign tree_we    = ctl.clear_step | ctl.tree_write;
  assign tree_waddr = ctl.clear_step ? clear_cnt : tree_addr;
  assign tree_wdata = ctl.clear_step ? '0 : (tree_rdata + delta);

  assign range_sum  = acc;

  fwk_ram #(
    .WIDTH (fwk_pkg::DATA_W),
    .DEPTH (fwk_pkg::NUM_ELEMENTS)
  ) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (elem_wdata),
    .raddr (index_r),
    .rdata (elem_rdata)
  );

  fwk_ram #(
    .WIDTH (fwk_pkg::DATA_W),
    .DEPTH (fwk_pkg::NUM_ELEMENTS)
  ) u_tree_ram (
    .clk   (clk),
    .we    (tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (tree_addr),
    .rdata (tree_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt <= '0;
    end else if (ctl.clear_step) begin
      clear_cnt <= clear_cnt + fwk_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      index_r <= index;
      left_r  <= left;
      value_r <= value;
      acc     <= '0;
      if (command == fwk_pkg::CMD_QUERY) begin
        node <= {1'b0, right} + fwk_pkg::NODE_W'(1);
      end
    end
    if (ctl.elem_write) begin
      delta <= value_r - elem_rdata;
    end
    if (ctl.load_up_node) begin
      node <= {1'b0, index_r} + fwk_pkg::NODE_W'(1);
    end
    if (ctl.step_up) begin
      node <= up_sum[fwk_pkg::NODE_W-1:0];
    end
    if (ctl.load_left) begin
      node <= {1'b0, left_r};
    end
    if (ctl.q_accum) begin
      acc  <= ctl.q_sub ? (acc - tree_rdata) : (acc + tree_rdata);
      node <= node & node_dec;
    end
  end

endmodule

[rtl/core/fwk_ctrl.sv]
// Controller FSM: clearing pass, set walk up the tree, two-chain prefix query.
// Depends on fwk_pkg.
module fwk_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          command,
  input  fwk_pkg::sts_t sts,
  output fwk_pkg::ctl_t ctl,
  output logic          busy,
  output logic          done
);

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b000_0000_0001,
    S_IDLE    = 11'b000_0000_0010,
    S_SET_RD  = 11'b000_0000_0100,
    S_SET_USE = 11'b000_0000_1000,
    S_UP_RD   = 11'b000_0001_0000,
    S_UP_USE  = 11'b000_0010_0000,
    S_QA_RD   = 11'b000_0100_0000,
    S_QA_USE  = 11'b000_1000_0000,
    S_QB_RD   = 11'b001_0000_0000,
    S_QB_USE  = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_CLEAR: begin
        ctl.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_next  = (command == fwk_pkg::CMD_SET) ? S_SET_RD : S_QA_RD;
        end
      end
      S_SET_RD: begin
        state_next = S_SET_USE;
      end
      S_SET_USE: begin
        ctl.elem_write   = 1'b1;
        ctl.load_up_node = 1'b1;
        state_next       = S_UP_RD;
      end
      S_UP_RD: begin
        state_next = S_UP_USE;
      end
      S_UP_USE: begin
        ctl.tree_write = 1'b1;
        ctl.step_up    = 1'b1;
        state_next     = sts.up_last ? S_IDLE : S_UP_RD;
      end
      S_QA_RD: begin
        if (sts.node_zero) begin
          ctl.load_left = 1'b1;
          state_next    = S_QB_RD;
        end else begin
          state_next = S_QA_USE;
        end
      end
      S_QA_USE: begin
        ctl.q_accum = 1'b1;
        state_next  = S_QA_RD;
      end
      S_QB_RD: begin
        state_next = sts.node_zero ? S_DONE : S_QB_USE;
      end
      S_QB_USE: begin
        ctl.q_accum = 1'b1;
        ctl.q_sub   = 1'b1;
        state_next  = S_QB_RD;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

[rtl/core/fenwick_point_set_range_sum.sv]
// Fenwick tree (binary indexed tree) over 1024 signed 32-bit elements:
// point set and range sum. A command is taken at a clock edge with start
// high and busy low. A set (command 0) replaces element index with value
// and produces no result; it walks up the covering tree nodes, reading
// and then updating each, with busy high throughout. A query (command 1)
// returns range_sum = prefix(right+1) - prefix(left), wrapped to 32 bits,
// negated-sum semantics when left > right. It walks both prefix chains in
// the single tree memory, reading and then accumulating each node. The
// result is on range_sum for exactly one cycle with done high, and that
// transfer cannot be stalled: capture it then. After reset the block runs
// a clearing pass that zeroes both memories, one address a cycle, with
// busy held high until it ends.
// Depends on fwk_pkg, fwk_ctrl, fwk_dp, fwk_ram and the assertion header.
`include "fenwick_point_set_range_sum_assert.svh"

module fenwick_point_set_range_sum (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [fwk_pkg::IDX_W-1:0]         index,
  input  logic signed [fwk_pkg::DATA_W-1:0] value,
  input  logic [fwk_pkg::IDX_W-1:0]         left,
  input  logic [fwk_pkg::IDX_W-1:0]         right,
  output logic                              done,
  output logic signed [fwk_pkg::DATA_W-1:0] range_sum
);

  fwk_pkg::ctl_t ctl;
  fwk_pkg::sts_t sts;

  // sequencing: clear pass, set walk, two query chains
  fwk_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .sts     (sts),
    .ctl     (ctl),
    .busy    (busy),
    .done    (done)
  );

  // memories, node arithmetic, delta and running sum
  fwk_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .command   (command),
    .index     (index),
    .value     (value),
    .left      (left),
    .right     (right),
    .range_sum (range_sum)
  );

  // a transfer always leaves the idle state
  `FWK_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
  // result strobe is a single cycle
  `FWK_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
  // no result while the block could take a new command
  `FWK_ASSERT_ALWAYS(a_done_busy, !done || busy, "done while idle")
  // clearing writes only happen with input blocked
  `FWK_ASSERT_ALWAYS(a_clear_busy, !ctl.clear_step || busy, "clear pass while accepting")

endmodule
